// ----- rtl/core/p2h_pkg.sv -----
// ----------------------------------------------------------------------------
// p2h_pkg: shared constants for the point to hex cell block
// Fixed-point coefficient builders (elaboration-time only) and format widths.
// ----------------------------------------------------------------------------
package p2h_pkg;

  localparam int PointW  = 24;   // point coordinate width, 8 fraction bits
  localparam int SizeW   = 16;   // cell size width, 8 fraction bits
  localparam int CoordW  = 16;   // output cube coordinate width
  localparam int SizeMin = 256;  // 1.0 in size format

  // integer square root, elaboration only
  function automatic longint unsigned isqrt(input longint unsigned a);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 0;
    bitv = 64'd1 << 62;
    rem  = a;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2/3 rounded to nearest, f fraction bits
  function automatic longint unsigned coef_two_thirds(input int f);
    return ((64'd1 << (f + 2)) + 64'd3) / 64'd6;
  endfunction

  // 1/3 rounded to nearest, f fraction bits
  function automatic longint unsigned coef_one_third(input int f);
    return ((64'd1 << (f + 1)) + 64'd3) / 64'd6;
  endfunction

  // sqrt(3)/3 rounded to nearest, f fraction bits
  function automatic longint unsigned coef_sqrt3_third(input int f);
    return (isqrt((64'd1 << (2 * f + 2)) / 64'd3) + 64'd1) >> 1;
  endfunction

endpackage

// ----- rtl/core/p2h_front.sv -----
// ----------------------------------------------------------------------------
// p2h_front: point intake and coefficient products
// Two stages: three constant multiplies, then the axial numerators as
// sign and magnitude, ready for the divider.
// ----------------------------------------------------------------------------
module p2h_front #(
  parameter int F  = 18,
  parameter int MW = F + 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  point_valid,
  output logic                                  point_ready,
  input  logic signed [p2h_pkg::PointW-1:0]     point_x,
  input  logic signed [p2h_pkg::PointW-1:0]     point_y,
  output logic                                  num_valid,
  input  logic                                  num_ready,
  output logic [2*MW+1:0]                       num_data
);

  localparam logic [F-1:0] C23 = F'(p2h_pkg::coef_two_thirds(F));
  localparam logic [F-1:0] C13 = F'(p2h_pkg::coef_one_third(F));
  localparam logic [F-1:0] CS3 = F'(p2h_pkg::coef_sqrt3_third(F));

  localparam int PW = F + p2h_pkg::PointW + 1;

  logic              en;
  logic              v1;
  logic              v2;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] prod_yr;
  logic signed [PW-1:0] prod_xr;
  logic signed [PW:0]   diff_r;
  logic [PW:0]          abs_q;
  logic [PW:0]          abs_r;
  logic              sign_q;
  logic              sign_r;
  logic [MW-1:0]     mag_q;
  logic [MW-1:0]     mag_r;

  assign en          = !v2 || num_ready;
  assign point_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= point_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q  <= $signed({1'b0, C23}) * point_x;
      prod_yr <= $signed({1'b0, CS3}) * point_y;
      prod_xr <= $signed({1'b0, C13}) * point_x;
    end
  end

  always_comb begin
    diff_r = {prod_yr[PW-1], prod_yr} - {prod_xr[PW-1], prod_xr};
    abs_q  = prod_q[PW-1] ? -{prod_q[PW-1], prod_q} : {prod_q[PW-1], prod_q};
    abs_r  = diff_r[PW] ? -diff_r : diff_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign_q <= prod_q[PW-1];
      sign_r <= diff_r[PW];
      mag_q  <= abs_q[MW-1:0];
      mag_r  <= abs_r[MW-1:0];
    end
  end

  assign num_valid = v2;
  assign num_data  = {sign_q, mag_q, sign_r, mag_r};

endmodule

// ----- rtl/core/p2h_queue.sv -----
// ----------------------------------------------------------------------------
// p2h_queue: two-entry queue between front and back
// Lets the front keep taking beats while the divider pipeline is stalled.
// ----------------------------------------------------------------------------
module p2h_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slot [0:1];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- rtl/core/p2h_back.sv -----
// ----------------------------------------------------------------------------
// p2h_back: divide by cell size, round to cube coordinates
// One restoring-divide bit per stage for q and r side by side, then s,
// rounding with errors, and the rebuild of the worst coordinate.
// ----------------------------------------------------------------------------
module p2h_back #(
  parameter int F  = 18,
  parameter int MW = F + 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [p2h_pkg::SizeW-1:0]            size,
  input  logic                                 num_valid,
  output logic                                 num_ready,
  input  logic [2*MW+1:0]                      num_data,
  output logic                                 cell_valid,
  input  logic                                 cell_ready,
  output logic signed [p2h_pkg::CoordW-1:0]    cell_q,
  output logic signed [p2h_pkg::CoordW-1:0]    cell_r,
  output logic signed [p2h_pkg::CoordW-1:0]    cell_s
);

  localparam int SW = p2h_pkg::SizeW;
  localparam int CW = p2h_pkg::CoordW;
  localparam int ND = MW - 8;   // quotient bits; top 8 bits seed the remainder
  localparam int VW = ND + 2;   // signed width of q, r, s with F fraction bits

  logic en;

  // divider lanes: index 0 is the queue head, 1..ND registered stages
  logic          vld   [0:ND];
  logic          sgn_q [0:ND];
  logic          sgn_r [0:ND];
  logic [SW-1:0] rem_q [0:ND];
  logic [SW-1:0] rem_r [0:ND];
  logic [ND-1:0] num_q [0:ND];
  logic [ND-1:0] num_r [0:ND];
  logic [ND-1:0] quo_q [0:ND];
  logic [ND-1:0] quo_r [0:ND];

  logic [MW-1:0] in_mag_q;
  logic [MW-1:0] in_mag_r;

  assign en        = !cell_valid || cell_ready;
  assign num_ready = en;

  assign in_mag_q  = num_data[2*MW:MW+1];
  assign in_mag_r  = num_data[MW-1:0];

  assign vld[0]   = num_valid;
  assign sgn_q[0] = num_data[2*MW+1];
  assign sgn_r[0] = num_data[MW];
  assign rem_q[0] = {{(SW-8){1'b0}}, in_mag_q[MW-1 -: 8]};
  assign rem_r[0] = {{(SW-8){1'b0}}, in_mag_r[MW-1 -: 8]};
  assign num_q[0] = in_mag_q[ND-1:0];
  assign num_r[0] = in_mag_r[ND-1:0];
  assign quo_q[0] = '0;
  assign quo_r[0] = '0;

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [SW:0] trial_q;
    logic [SW:0] trial_r;
    logic        ge_q;
    logic        ge_r;
    logic [SW:0] diff_q;
    logic [SW:0] diff_r;

    always_comb begin
      trial_q = {rem_q[k], num_q[k][ND-1]};
      trial_r = {rem_r[k], num_r[k][ND-1]};
      ge_q    = trial_q >= {1'b0, size};
      ge_r    = trial_r >= {1'b0, size};
      diff_q  = ge_q ? trial_q - {1'b0, size} : trial_q;
      diff_r  = ge_r ? trial_r - {1'b0, size} : trial_r;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sgn_q[k+1] <= sgn_q[k];
        sgn_r[k+1] <= sgn_r[k];
        rem_q[k+1] <= diff_q[SW-1:0];
        rem_r[k+1] <= diff_r[SW-1:0];
        num_q[k+1] <= num_q[k] << 1;
        num_r[k+1] <= num_r[k] << 1;
        quo_q[k+1] <= {quo_q[k][ND-2:0], ge_q};
        quo_r[k+1] <= {quo_r[k][ND-2:0], ge_r};
      end
    end
  end

  // signed q, r, s with F fraction bits
  logic                 v_frac;
  logic signed [VW-1:0] frac_v [0:2];
  logic signed [VW-1:0] qf_next;
  logic signed [VW-1:0] rf_next;

  always_comb begin
    qf_next = sgn_q[ND] ? -$signed({2'b00, quo_q[ND]}) : $signed({2'b00, quo_q[ND]});
    rf_next = sgn_r[ND] ? -$signed({2'b00, quo_r[ND]}) : $signed({2'b00, quo_r[ND]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_frac <= 1'b0;
    end else if (en) begin
      v_frac <= vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac_v[0] <= qf_next;
      frac_v[1] <= rf_next;
      frac_v[2] <= -(qf_next + rf_next);
    end
  end

  // round halves away from zero; error is the distance to the chosen integer
  logic          v_rnd;
  logic [CW-1:0] rnd [0:2];
  logic [F:0]    err [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_rnd
    logic [VW-1:0] mag;
    logic [F-1:0]  fr;
    logic          up;
    logic [CW-1:0] whole;

    always_comb begin
      mag   = frac_v[c][VW-1] ? -frac_v[c] : frac_v[c];
      fr    = mag[F-1:0];
      up    = fr[F-1];
      whole = mag[F+CW-1:F] + {{(CW-1){1'b0}}, up};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rnd[c] <= frac_v[c][VW-1] ? -whole : whole;
        err[c] <= up ? ({1'b1, {F{1'b0}}} - {1'b0, fr}) : {1'b0, fr};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rnd <= 1'b0;
    end else if (en) begin
      v_rnd <= v_frac;
    end
  end

  // rebuild the coordinate with the strictly largest error; ties favor s, then r
  logic fix_q;
  logic fix_r;

  assign fix_q = (err[0] > err[1]) && (err[0] > err[2]);
  assign fix_r = !fix_q && (err[1] > err[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (en) begin
      cell_valid <= v_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_q <= fix_q ? -(rnd[1] + rnd[2]) : rnd[0];
      cell_r <= fix_r ? -(rnd[0] + rnd[2]) : rnd[1];
      cell_s <= (!fix_q && !fix_r) ? -(rnd[0] + rnd[1]) : rnd[2];
    end
  end

`ifndef SYNTHESIS
  a_cube_sum: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> (CW'(cell_q + cell_r + cell_s) == '0))
    else $error("cube coordinates do not sum to zero");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (en && v_rnd) |=> cell_valid)
    else $error("rounded beat lost before output register");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v_rnd) && $stable(v_frac) && $stable(vld[ND])))
    else $error("back pipeline moved during stall");
`endif

endmodule

// ----- rtl/core/point_to_hex_cell.sv -----
// ----------------------------------------------------------------------------
// point_to_hex_cell: point to flat-top hex cell in cube coordinates
// Maps a fixed-point 2-D point to the containing hexagon (q, r, s).
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  point    | point_valid, point_ready, point_x/y       | in
//  cell     | cell_valid, cell_ready, cell_q/r/s        | out
//  config   | cell_size_we, cell_size                   | in
//
//  One beat per cycle sustained while cell_ready stays high. Stages in order:
//  2 front stages, one queue slot, CONST_FRAC_BITS + 16 divide stages
//  (one quotient bit each, from the pipelined restoring divider), then
//  s, rounding and the output register.
//  Reset (rst, synchronous) empties the pipeline and sets the size to 1.0.
//  A cell stall freezes the back part; the two-slot queue and front fill up
//  before point_ready drops.
//
module point_to_hex_cell #(
  parameter int CONST_FRAC_BITS = 18
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 point_valid,
  output logic                                 point_ready,
  input  logic signed [p2h_pkg::PointW-1:0]    point_x,
  input  logic signed [p2h_pkg::PointW-1:0]    point_y,
  output logic                                 cell_valid,
  input  logic                                 cell_ready,
  output logic signed [p2h_pkg::CoordW-1:0]    cell_q,
  output logic signed [p2h_pkg::CoordW-1:0]    cell_r,
  output logic signed [p2h_pkg::CoordW-1:0]    cell_s,
  input  logic                                 cell_size_we,
  input  logic [p2h_pkg::SizeW-1:0]            cell_size
);

  // numerator magnitude: coefficient (< 1.0) times a 24-bit point
  localparam int MW = CONST_FRAC_BITS + p2h_pkg::PointW;
  localparam logic [p2h_pkg::SizeW-1:0] SizeFloor = p2h_pkg::SizeW'(p2h_pkg::SizeMin);

  logic [p2h_pkg::SizeW-1:0] size;      // clamped to at least 1.0 on write
  logic                      num_valid;
  logic                      num_ready;
  logic [2*MW+1:0]           num_data;
  logic                      head_valid;
  logic                      head_ready;
  logic [2*MW+1:0]           head_data;

  // sizes below 1.0 (zero included) behave as 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SizeFloor;
    end else if (cell_size_we) begin
      size <= (cell_size < SizeFloor) ? SizeFloor : cell_size;
    end
  end

  p2h_front #(
    .F  (CONST_FRAC_BITS),
    .MW (MW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .num_valid   (num_valid),
    .num_ready   (num_ready),
    .num_data    (num_data)
  );

  // decouples front from a stalled divider
  p2h_queue #(
    .W (2*MW+2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_data   (num_data),
    .out_valid (head_valid),
    .out_ready (head_ready),
    .out_data  (head_data)
  );

  p2h_back #(
    .F  (CONST_FRAC_BITS),
    .MW (MW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .size       (size),
    .num_valid  (head_valid),
    .num_ready  (head_ready),
    .num_data   (head_data),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_q     (cell_q),
    .cell_r     (cell_r),
    .cell_s     (cell_s)
  );

endmodule
